// ----- src/tss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

  localparam int unsigned NOW_W   = 32;
  localparam int unsigned REF_W   = 8;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;
  // Wide enough for slot start sums and signed slot limits without wrap.
  localparam int unsigned TIME_W  = 40;
  // Dividend width of the remainder unit: the distance past a slot limit.
  localparam int unsigned DIV_DW  = 34;

  localparam int unsigned DEF_QUEUE_DEPTH = 8;

  localparam logic [SLOT_W-1:0] RST_SLOT_INDEX   = 4'd0;
  localparam logic [CFG_W-1:0]  RST_SLOT_LENGTH  = 32'd10922;
  localparam logic [CFG_W-1:0]  RST_GUARD_TIME   = 32'd2730;
  localparam logic [CFG_W-1:0]  RST_PERIOD       = 32'd32768;

  typedef enum logic [1:0] {
    ACT_ENQUEUE   = 2'd0,
    ACT_TIMER     = 2'd1,
    ACT_SEND_DONE = 2'd2,
    ACT_NONE      = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    KIND_QUEUED       = 3'd0,
    KIND_QUEUED_TIMER = 3'd1,
    KIND_DROPPED      = 3'd2,
    KIND_TRANSMIT     = 3'd3,
    KIND_SLEEP        = 3'd4
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOT_INDEX  = 2'd0,
    CFG_SLOT_LENGTH = 2'd1,
    CFG_GUARD_TIME  = 2'd2,
    CFG_PERIOD      = 2'd3
  } cfg_idx_e;

endpackage

`default_nettype wire

// ----- src/tss_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tss_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [tss_pkg::NOW_W-1:0]     now;
  logic [tss_pkg::REF_W-1:0]     packet_ref;
  logic                          send_ok;

  modport source (output valid, action, now, packet_ref, send_ok, input ready);
  modport sink   (input valid, action, now, packet_ref, send_ok, output ready);
endinterface

interface tss_res_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    kind;
  logic [tss_pkg::REF_W-1:0]     packet_ref_out;
  logic [tss_pkg::ID_W-1:0]      packet_id;
  logic [tss_pkg::NOW_W-1:0]     wake_time;
  logic [tss_pkg::ID_W-1:0]      sent_total;

  modport source (output valid, kind, packet_ref_out, packet_id, wake_time, sent_total,
                  input ready);
  modport sink   (input valid, kind, packet_ref_out, packet_id, wake_time, sent_total,
                  output ready);
endinterface

`default_nettype wire

// ----- src/tss_ring_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tss_ring_mem #(
  parameter int unsigned DEPTH = tss_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned DW    = tss_pkg::ID_W + tss_pkg::REF_W
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/tss_rem_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring remainder unit: one dividend bit per cycle, done pulses once.
module tss_rem_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [tss_pkg::DIV_DW-1:0]   dividend_i,
  input  wire logic [tss_pkg::CFG_W-1:0]    divisor_i,
  output logic                              done_o,
  output logic      [tss_pkg::CFG_W-1:0]    rem_o
);

  localparam int unsigned DW  = tss_pkg::DIV_DW;
  localparam int unsigned VW  = tss_pkg::CFG_W;
  localparam int unsigned CNTW = $clog2(DW + 1);

  logic [DW-1:0]   quo_q, quo_d;
  logic [VW-1:0]   rem_q, rem_d;
  logic [VW-1:0]   div_q, div_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [VW:0]     trial;

  assign trial = {rem_q, quo_q[DW-1]};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = CNTW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = VW'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[VW-1:0];
      end
      quo_d = {quo_q[DW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ----- src/tdma_slot_tx_scheduler.sv -----
`timescale 1ns / 1ps
`default_nettype none

// TDMA transmit scheduler.
// Requests arrive on req_i (valid/ready): enqueue a packet handle, a timer event
// or a send-done event, each carrying the current tick. Every request that
// calls for an answer yields exactly one result on res_o (valid/ready); a stray
// send-done, a timer event during a pending transmission and the unused action
// code are absorbed without a result. Configuration (slot index, slot length,
// guard time, period) is written through cfg_we_i/cfg_idx_i/cfg_data_i; the
// user must write it only while the block is idle, which the block does not enforce.
// Queued packets live in a ring memory with a registered read port; the ring is
// written on enqueue and read when a transmission is answered.
// The timer path runs through the shared remainder unit, which resolves one
// bit per cycle in at most two passes, the second only when the current tick
// lies past the slot limit. One request is handled at a time; the next one is
// taken as soon as the current one has reached the output register.
// Reset empties the ring, clears all counters, stops the timer flag and loads
// the default configuration. When the receiver stalls, the finished result
// waits in the output register; the block may take one more request and
// then holds that one's result until the register frees.
module tdma_slot_tx_scheduler #(
  parameter int unsigned QUEUE_DEPTH = tss_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [tss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tss_pkg::CFG_W-1:0]      cfg_data_i,
  tss_req_if.sink                             req_i,
  tss_res_if.source                           res_o
);

  localparam int unsigned PW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned TW  = tss_pkg::TIME_W;
  localparam int unsigned NW  = tss_pkg::NOW_W;
  localparam int unsigned CW  = tss_pkg::CFG_W;
  localparam int unsigned IW  = tss_pkg::ID_W;
  localparam int unsigned RW  = tss_pkg::REF_W;
  localparam int unsigned SW  = tss_pkg::SLOT_W;
  localparam int unsigned DDW = tss_pkg::DIV_DW;
  localparam int unsigned MW  = IW + RW;
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_ENQ  = 10'b00_0000_0010,
    ST_TDIV = 10'b00_0000_0100,
    ST_TLIM = 10'b00_0000_1000,
    ST_TDEC = 10'b00_0001_0000,
    ST_TFIX = 10'b00_0010_0000,
    ST_SEND = 10'b00_0100_0000,
    ST_READ = 10'b00_1000_0000,
    ST_EMIT = 10'b01_0000_0000,
    ST_TSUM = 10'b10_0000_0000
  } state_e;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    ring_next = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // Configuration registers.
  logic [SW-1:0] slot_idx_q;
  logic [CW-1:0] slot_len_q, guard_q, period_q;
  logic [CW-1:0] eff_per;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_idx_q <= tss_pkg::RST_SLOT_INDEX;
      slot_len_q <= tss_pkg::RST_SLOT_LENGTH;
      guard_q    <= tss_pkg::RST_GUARD_TIME;
      period_q   <= tss_pkg::RST_PERIOD;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tss_pkg::CFG_SLOT_INDEX:  slot_idx_q <= cfg_data_i[SW-1:0];
        tss_pkg::CFG_SLOT_LENGTH: slot_len_q <= cfg_data_i;
        tss_pkg::CFG_GUARD_TIME:  guard_q    <= cfg_data_i;
        tss_pkg::CFG_PERIOD:      period_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A zero period behaves as a period of one tick.
  assign eff_per = (period_q == '0) ? CW'(1) : period_q;

  // Control state.
  state_e        state_q, state_d;
  logic [PW-1:0] send_ptr_q, send_ptr_d;
  logic [PW-1:0] free_ptr_q, free_ptr_d;
  logic          timer_run_q, timer_run_d;
  logic          tx_active_q, tx_active_d;
  logic [NW-1:0] css_q, css_d;
  logic [IW-1:0] id_cnt_q, id_cnt_d;
  logic [IW-1:0] succ_q, succ_d;
  logic          out_valid_q, out_valid_d;

  // Request and working registers.
  logic [NW-1:0] now_q, now_d;
  logic [RW-1:0] pref_q, pref_d;
  logic          ok_q, ok_d;
  logic [TW-1:0] prod_q, prod_d;
  logic [TW-1:0] s_q, s_d;
  logic [TW-1:0] lim_q, lim_d;
  logic [DDW-1:0] dist_q, dist_d;

  // Pending result.
  tss_pkg::kind_e res_kind_q, res_kind_d;
  logic [IW-1:0]  res_id_q, res_id_d;
  logic [NW-1:0]  res_wake_q, res_wake_d;
  logic           res_mem_q, res_mem_d;

  // Output register.
  logic [2:0]    o_kind_q, o_kind_d;
  logic [RW-1:0] o_ref_q, o_ref_d;
  logic [IW-1:0] o_id_q, o_id_d;
  logic [NW-1:0] o_wake_q, o_wake_d;
  logic [IW-1:0] o_sent_q, o_sent_d;

  // Ring memory and remainder unit.
  logic          mem_we, mem_re;
  logic [PW-1:0] mem_raddr;
  logic [MW-1:0] mem_wdata, mem_rdata;
  logic          div_start, div_done;
  logic [DDW-1:0] div_dividend;
  logic [CW-1:0] div_rem;

  tss_ring_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (PW),
    .DW    (MW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (free_ptr_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  tss_rem_unit u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (eff_per),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  logic          in_fire;
  logic [IW-1:0] id_next;
  logic [PW-1:0] send_next;
  logic [TW-1:0] now_x;
  logic [TW-1:0] send_lim;
  logic          past_lim;
  logic [TW-1:0] adj;

  assign req_i.ready = (state_q == ST_IDLE);
  assign in_fire     = req_i.valid && req_i.ready;
  assign id_next     = id_cnt_q + 1'b1;
  assign send_next   = ring_next(send_ptr_q);
  assign now_x       = TW'(now_q);
  // Last tick at which a transmission may still start in the current slot.
  assign send_lim    = TW'(css_q) + TW'(slot_len_q) - TW'(guard_q);
  assign past_lim    = $signed(now_x) > $signed(lim_q);
  // Rounds the distance past the limit up to a whole number of periods.
  assign adj         = (div_rem == '0) ? '0 : TW'(eff_per - div_rem);

  always_comb begin
    state_d      = state_q;
    send_ptr_d   = send_ptr_q;
    free_ptr_d   = free_ptr_q;
    timer_run_d  = timer_run_q;
    tx_active_d  = tx_active_q;
    css_d        = css_q;
    id_cnt_d     = id_cnt_q;
    succ_d       = succ_q;
    out_valid_d  = out_valid_q;
    now_d        = now_q;
    pref_d       = pref_q;
    ok_d         = ok_q;
    prod_d       = prod_q;
    s_d          = s_q;
    lim_d        = lim_q;
    dist_d       = dist_q;
    res_kind_d   = res_kind_q;
    res_id_d     = res_id_q;
    res_wake_d   = res_wake_q;
    res_mem_d    = res_mem_q;
    o_kind_d     = o_kind_q;
    o_ref_d      = o_ref_q;
    o_id_d       = o_id_q;
    o_wake_d     = o_wake_q;
    o_sent_d     = o_sent_q;
    mem_we       = 1'b0;
    mem_wdata    = {id_cnt_q, pref_q};
    mem_re       = 1'b0;
    mem_raddr    = send_ptr_q;
    div_start    = 1'b0;
    div_dividend = DDW'(req_i.now);

    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          now_d  = req_i.now;
          pref_d = req_i.packet_ref;
          ok_d   = req_i.send_ok;
          prod_d = TW'(slot_idx_q) * TW'(slot_len_q);
          case (req_i.action)
            tss_pkg::ACT_ENQUEUE: state_d = ST_ENQ;
            tss_pkg::ACT_TIMER: begin
              if (!tx_active_q) begin
                div_start = 1'b1;
                state_d   = ST_TDIV;
              end
            end
            tss_pkg::ACT_SEND_DONE: begin
              if (tx_active_q) begin
                state_d = ST_SEND;
              end
            end
            default: ;
          endcase
        end
      end

      ST_ENQ: begin
        id_cnt_d  = id_next;
        res_id_d  = id_next;
        res_mem_d = 1'b0;
        res_wake_d = '0;
        if (ring_next(free_ptr_q) == send_ptr_q) begin
          res_kind_d = tss_pkg::KIND_DROPPED;
        end else begin
          mem_we     = 1'b1;
          mem_wdata  = {id_next, pref_q};
          free_ptr_d = ring_next(free_ptr_q);
          if (!timer_run_q) begin
            timer_run_d = 1'b1;
            res_kind_d  = tss_pkg::KIND_QUEUED_TIMER;
            res_wake_d  = now_q + eff_per;
          end else begin
            res_kind_d  = tss_pkg::KIND_QUEUED;
          end
        end
        state_d = ST_EMIT;
      end

      ST_TDIV: begin
        if (div_done) begin
          s_d     = TW'(now_q - div_rem);
          state_d = ST_TSUM;
        end
      end

      ST_TSUM: begin
        s_d     = s_q + prod_q;
        state_d = ST_TLIM;
      end

      ST_TLIM: begin
        lim_d   = s_q + TW'(slot_len_q) - TW'(guard_q);
        state_d = ST_TDEC;
      end

      ST_TDEC: begin
        res_id_d  = '0;
        res_mem_d = 1'b0;
        if (past_lim) begin
          dist_d       = DDW'(now_x - lim_q);
          div_dividend = DDW'(now_x - lim_q);
          div_start    = 1'b1;
          state_d      = ST_TFIX;
        end else if (now_x < s_q) begin
          tx_active_d = 1'b0;
          res_kind_d  = tss_pkg::KIND_SLEEP;
          res_wake_d  = s_q[NW-1:0];
          state_d     = ST_EMIT;
        end else begin
          css_d = s_q[NW-1:0];
          if (send_ptr_q != free_ptr_q) begin
            tx_active_d = 1'b1;
            res_kind_d  = tss_pkg::KIND_TRANSMIT;
            res_wake_d  = '0;
            res_mem_d   = 1'b1;
            state_d     = ST_READ;
          end else begin
            tx_active_d = 1'b0;
            res_kind_d  = tss_pkg::KIND_SLEEP;
            res_wake_d  = NW'(s_q + TW'(eff_per));
            state_d     = ST_EMIT;
          end
        end
      end

      ST_TFIX: begin
        if (div_done) begin
          tx_active_d = 1'b0;
          res_kind_d  = tss_pkg::KIND_SLEEP;
          res_wake_d  = NW'(s_q + TW'(dist_q) + adj);
          state_d     = ST_EMIT;
        end
      end

      ST_SEND: begin
        if (ok_q) begin
          succ_d = succ_q + 1'b1;
        end
        send_ptr_d = send_next;
        res_id_d   = '0;
        if (($signed(now_x) > $signed(send_lim)) || (send_next == free_ptr_q)) begin
          tx_active_d = 1'b0;
          res_kind_d  = tss_pkg::KIND_SLEEP;
          res_wake_d  = css_q + eff_per;
          res_mem_d   = 1'b0;
          state_d     = ST_EMIT;
        end else begin
          res_kind_d  = tss_pkg::KIND_TRANSMIT;
          res_wake_d  = '0;
          res_mem_d   = 1'b1;
          state_d     = ST_READ;
        end
      end

      ST_READ: begin
        mem_re  = 1'b1;
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          o_kind_d    = res_kind_q;
          o_ref_d     = res_mem_q ? mem_rdata[RW-1:0] : '0;
          o_id_d      = res_mem_q ? mem_rdata[MW-1:RW] : res_id_q;
          o_wake_d    = res_wake_q;
          o_sent_d    = succ_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      send_ptr_q  <= '0;
      free_ptr_q  <= '0;
      timer_run_q <= 1'b0;
      tx_active_q <= 1'b0;
      css_q       <= '0;
      id_cnt_q    <= '0;
      succ_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      send_ptr_q  <= send_ptr_d;
      free_ptr_q  <= free_ptr_d;
      timer_run_q <= timer_run_d;
      tx_active_q <= tx_active_d;
      css_q       <= css_d;
      id_cnt_q    <= id_cnt_d;
      succ_q      <= succ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    pref_q     <= pref_d;
    ok_q       <= ok_d;
    prod_q     <= prod_d;
    s_q        <= s_d;
    lim_q      <= lim_d;
    dist_q     <= dist_d;
    res_kind_q <= res_kind_d;
    res_id_q   <= res_id_d;
    res_wake_q <= res_wake_d;
    res_mem_q  <= res_mem_d;
    o_kind_q   <= o_kind_d;
    o_ref_q    <= o_ref_d;
    o_id_q     <= o_id_d;
    o_wake_q   <= o_wake_d;
    o_sent_q   <= o_sent_d;
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.kind           = o_kind_q;
  assign res_o.packet_ref_out = o_ref_q;
  assign res_o.packet_id      = o_id_q;
  assign res_o.wake_time      = o_wake_q;
  assign res_o.sent_total     = o_sent_q;

endmodule

`default_nettype wire
